// ----- rtl/core/tpfm_pkg.sv -----
// ----------------------------------------------------------------------------
// tpfm_pkg
// Shared constants, types and helpers of the touch point filter and mapper.
// ----------------------------------------------------------------------------
package tpfm_pkg;

  localparam int SAMPLES    = 5;
  localparam int CNT_W      = $clog2(SAMPLES + 1);
  localparam int SUM_W      = 16;
  localparam int RAW_W      = 12;
  localparam int PT_W       = 9;
  localparam int HOLD_W     = 8;
  localparam int ORIENT_W   = 3;
  localparam int ROT_W      = 2;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int DIV_N_W    = 21;
  localparam int DIV_D_W    = 12;
  localparam int SPAN_W     = RAW_W + 1;
  localparam int PROD_W     = 23;
  localparam int MAP_W      = 24;
  localparam int FIFO_DEPTH = 2;

  localparam logic [CNT_W-1:0] MIN_VALID = CNT_W'(2);
  localparam logic [PT_W-1:0]  MAX_COL   = PT_W'(239);
  localparam logic [PT_W-1:0]  MAX_ROW   = PT_W'(319);

  localparam logic [CFG_IDX_W-1:0] REG_CAL_X_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_X_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_HOLD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENT_FLAGS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROT   = 3'd7;

  typedef struct packed {
    logic [RAW_W-1:0]    cal_x_low;
    logic [RAW_W-1:0]    cal_x_high;
    logic [RAW_W-1:0]    cal_y_low;
    logic [RAW_W-1:0]    cal_y_high;
    logic [RAW_W-1:0]    pressure_min;
    logic [HOLD_W-1:0]   release_hold;
    logic [ORIENT_W-1:0] orient_flags;
    logic [ROT_W-1:0]    screen_rotation;
  } cfg_t;

  typedef struct packed {
    logic             cmd;
    logic             pressed;
    logic [RAW_W-1:0] sample_x;
    logic [RAW_W-1:0] sample_y;
    logic [RAW_W-1:0] sample_z;
  } in_item_t;

  typedef struct packed {
    logic             active;
    logic [PT_W-1:0]  point_x;
    logic [PT_W-1:0]  point_y;
    logic [RAW_W-1:0] avg_x;
    logic [RAW_W-1:0] avg_y;
    logic [RAW_W-1:0] avg_z;
  } out_item_t;

  typedef struct packed {
    logic             is_clear;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [SUM_W-1:0] sum_z;
    logic [CNT_W-1:0] count;
  } job_t;

  function automatic logic [PT_W-1:0] clamp_pt(input logic signed [MAP_W-1:0] v,
                                               input logic [PT_W-1:0] hi);
    logic signed [MAP_W-1:0] hi_s;
    hi_s = $signed({{(MAP_W-PT_W){1'b0}}, hi});
    if (v < 0) begin
      return '0;
    end else if (v > hi_s) begin
      return hi;
    end else begin
      return v[PT_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/core/tpfm_if.sv -----
// ----------------------------------------------------------------------------
// tpfm_if
// Valid/ready channels for raw samples and for screen points.
// ----------------------------------------------------------------------------
interface tpfm_in_if;
  import tpfm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tpfm_out_if;
  import tpfm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/tpfm_front.sv -----
// ----------------------------------------------------------------------------
// tpfm_front
// Accepts samples, filters on pressure, accumulates a frame and queues jobs.
// ----------------------------------------------------------------------------
module tpfm_front (
  input  logic            clk,
  input  logic            rst,
  tpfm_in_if.sink         in_ch,
  input  tpfm_pkg::cfg_t  cfg,
  output logic            push,
  output tpfm_pkg::job_t  push_job,
  input  logic            full
);
  import tpfm_pkg::*;

  logic [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic [SUM_W-1:0] sum_x_next, sum_y_next, sum_z_next;
  logic [CNT_W-1:0] valid_count, valid_count_next;
  logic [CNT_W-1:0] sample_index, sample_index_next;
  logic             accept;
  logic             take;
  logic             frame_end;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  always_comb begin
    take = in_ch.payload.pressed && (in_ch.payload.sample_z >= cfg.pressure_min);
    sum_x_next        = take ? sum_x + SUM_W'(in_ch.payload.sample_x) : sum_x;
    sum_y_next        = take ? sum_y + SUM_W'(in_ch.payload.sample_y) : sum_y;
    sum_z_next        = take ? sum_z + SUM_W'(in_ch.payload.sample_z) : sum_z;
    valid_count_next  = take ? valid_count + CNT_W'(1) : valid_count;
    sample_index_next = sample_index + CNT_W'(1);
    frame_end         = !in_ch.payload.cmd && (sample_index_next == CNT_W'(SAMPLES));
  end

  assign push              = accept && (in_ch.payload.cmd || frame_end);
  assign push_job.is_clear = in_ch.payload.cmd;
  assign push_job.sum_x    = sum_x_next;
  assign push_job.sum_y    = sum_y_next;
  assign push_job.sum_z    = sum_z_next;
  assign push_job.count    = valid_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x        <= '0;
      sum_y        <= '0;
      sum_z        <= '0;
      valid_count  <= '0;
      sample_index <= '0;
    end else if (accept && !in_ch.payload.cmd) begin
      if (frame_end) begin
        sum_x        <= '0;
        sum_y        <= '0;
        sum_z        <= '0;
        valid_count  <= '0;
        sample_index <= '0;
      end else begin
        sum_x        <= sum_x_next;
        sum_y        <= sum_y_next;
        sum_z        <= sum_z_next;
        valid_count  <= valid_count_next;
        sample_index <= sample_index_next;
      end
    end
  end

endmodule

// ----- rtl/core/tpfm_fifo.sv -----
// ----------------------------------------------------------------------------
// tpfm_fifo
// Short job queue between the sample front end and the mapping back end.
// ----------------------------------------------------------------------------
module tpfm_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tpfm_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output tpfm_pkg::job_t  pop_job,
  output logic            empty
);
  import tpfm_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

  job_t             slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [LVL_W-1:0] level;
  logic             do_push, do_pop;

  assign full    = (level == LVL_W'(FIFO_DEPTH));
  assign empty   = (level == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        level <= level + LVL_W'(1);
      end else if (do_pop && !do_push) begin
        level <= level - LVL_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/tpfm_div.sv -----
// ----------------------------------------------------------------------------
// tpfm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpfm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tpfm_pkg::DIV_N_W-1:0] num,
  input  logic [tpfm_pkg::DIV_D_W-1:0] den,
  output logic [tpfm_pkg::DIV_N_W-1:0] quo,
  output logic                         done
);
  import tpfm_pkg::*;

  localparam int STEP_W = $clog2(DIV_N_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W-1:0] den_r;
  logic [DIV_D_W:0]   rem_sh;
  logic               fits;

  always_comb begin
    rem_sh = {rem, quo[DIV_N_W-1]};
    fits   = (rem_sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      quo <= {quo[DIV_N_W-2:0], fits};
      rem <= fits ? DIV_D_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_D_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + STEP_W'(1);
        end
      end
    end
  end

endmodule

// ----- rtl/core/tpfm_back.sv -----
// ----------------------------------------------------------------------------
// tpfm_back
// Averages a frame, maps it onto the panel, orients it and tracks release.
// ----------------------------------------------------------------------------
module tpfm_back (
  input  logic            clk,
  input  logic            rst,
  input  tpfm_pkg::cfg_t  cfg,
  input  tpfm_pkg::job_t  pop_job,
  input  logic            empty,
  output logic            pop,
  tpfm_out_if.source      out_ch
);
  import tpfm_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_AVG   = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIVST = 3'd3;
  localparam logic [2:0] ST_MAP   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  localparam logic [1:0] K_POINT = 2'd0;
  localparam logic [1:0] K_HOLD  = 2'd1;
  localparam logic [1:0] K_OFF   = 2'd2;

  logic [2:0]  state;
  logic [1:0]  kind;
  logic        latched;
  logic [PT_W-1:0]   latch_x, latch_y;
  logic [HOLD_W-1:0] miss_count;
  logic [RAW_W-1:0]  avg_x, avg_y, avg_z;
  logic signed [PROD_W-1:0] prod_c, prod_r;
  logic signed [SPAN_W-1:0] span_c, span_r;
  logic [DIV_N_W-1:0] q_c, q_r;
  logic               out_valid;
  out_item_t          out_item;

  logic               div_start;
  logic [DIV_N_W-1:0] num0, num1, num2;
  logic [DIV_D_W-1:0] den0, den1, den2;
  logic [DIV_N_W-1:0] quo0, quo1, quo2;
  logic               done0, done1, done2;
  logic               div_done;

  logic               slot_free;
  logic               start_avg;
  logic signed [SPAN_W-1:0] span_c_w, span_r_w;
  logic signed [SPAN_W-1:0] diff_c, diff_r;
  logic signed [PROD_W-1:0] prod_c_w, prod_r_w;
  logic [PROD_W-1:0]  abs_c, abs_r;
  logic [SPAN_W-1:0]  sabs_c, sabs_r;
  logic signed [MAP_W-1:0] sx, sy, px_s, py_s;
  logic [PT_W-1:0]    px, py, qx, qy;

  assign slot_free = !out_valid || out_ch.ready;
  assign pop       = (state == ST_IDLE) && !empty;
  assign start_avg = pop && !pop_job.is_clear && (pop_job.count >= MIN_VALID);
  assign div_start = start_avg || (state == ST_DIVST);
  assign div_done  = done0 && done1 && done2;

  // column mapping from y, row mapping from x
  always_comb begin
    span_c_w = $signed({1'b0, cfg.cal_y_high}) - $signed({1'b0, cfg.cal_y_low});
    span_r_w = $signed({1'b0, cfg.cal_x_high}) - $signed({1'b0, cfg.cal_x_low});
    diff_c   = $signed({1'b0, avg_y}) - $signed({1'b0, cfg.cal_y_low});
    diff_r   = $signed({1'b0, avg_x}) - $signed({1'b0, cfg.cal_x_low});
    prod_c_w = PROD_W'(diff_c) * $signed({{(PROD_W-PT_W){1'b0}}, MAX_COL});
    prod_r_w = PROD_W'(diff_r) * $signed({{(PROD_W-PT_W){1'b0}}, MAX_ROW});
    abs_c  = prod_c[PROD_W-1] ? PROD_W'(-prod_c) : PROD_W'(prod_c);
    abs_r  = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
    sabs_c = span_c[SPAN_W-1] ? SPAN_W'(-span_c) : SPAN_W'(span_c);
    sabs_r = span_r[SPAN_W-1] ? SPAN_W'(-span_r) : SPAN_W'(span_r);
  end

  always_comb begin
    if (state == ST_IDLE) begin
      num0 = DIV_N_W'(pop_job.sum_x);
      num1 = DIV_N_W'(pop_job.sum_y);
      num2 = DIV_N_W'(pop_job.sum_z);
      den0 = DIV_D_W'(pop_job.count);
      den1 = DIV_D_W'(pop_job.count);
      den2 = DIV_D_W'(pop_job.count);
    end else begin
      num0 = abs_c[DIV_N_W-1:0];
      num1 = abs_r[DIV_N_W-1:0];
      num2 = '0;
      den0 = sabs_c[DIV_D_W-1:0];
      den1 = sabs_r[DIV_D_W-1:0];
      den2 = DIV_D_W'(1);
    end
  end

  tpfm_div u_div0 (.clk, .rst, .start(div_start), .num(num0), .den(den0),
                   .quo(quo0), .done(done0));
  tpfm_div u_div1 (.clk, .rst, .start(div_start), .num(num1), .den(den1),
                   .quo(quo1), .done(done1));
  tpfm_div u_div2 (.clk, .rst, .start(div_start), .num(num2), .den(den2),
                   .quo(quo2), .done(done2));

  // signed quotient, mirror, swap, clamp, rotate
  always_comb begin
    if (span_c == '0) begin
      sx = '0;
    end else if (prod_c[PROD_W-1] ^ span_c[SPAN_W-1]) begin
      sx = -$signed({{(MAP_W-DIV_N_W){1'b0}}, q_c});
    end else begin
      sx = $signed({{(MAP_W-DIV_N_W){1'b0}}, q_c});
    end
    if (span_r == '0) begin
      sy = '0;
    end else if (prod_r[PROD_W-1] ^ span_r[SPAN_W-1]) begin
      sy = -$signed({{(MAP_W-DIV_N_W){1'b0}}, q_r});
    end else begin
      sy = $signed({{(MAP_W-DIV_N_W){1'b0}}, q_r});
    end
    if (cfg.orient_flags[0]) begin
      sx = $signed({{(MAP_W-PT_W){1'b0}}, MAX_COL}) - sx;
    end
    if (cfg.orient_flags[1]) begin
      sy = $signed({{(MAP_W-PT_W){1'b0}}, MAX_ROW}) - sy;
    end
    px_s = cfg.orient_flags[2] ? sy : sx;
    py_s = cfg.orient_flags[2] ? sx : sy;
    px   = clamp_pt(px_s, MAX_COL);
    py   = clamp_pt(py_s, MAX_ROW);
    case (cfg.screen_rotation)
      2'd1: begin
        qx = py;
        qy = MAX_COL - px;
      end
      2'd2: begin
        qx = MAX_COL - px;
        qy = MAX_ROW - py;
      end
      2'd3: begin
        qx = MAX_ROW - py;
        qy = px;
      end
      default: begin
        qx = px;
        qy = py;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_AVG: begin
        if (div_done) begin
          avg_x <= quo0[RAW_W-1:0];
          avg_y <= quo1[RAW_W-1:0];
          avg_z <= quo2[RAW_W-1:0];
        end
      end
      ST_MUL: begin
        prod_c <= prod_c_w;
        prod_r <= prod_r_w;
        span_c <= span_c_w;
        span_r <= span_r_w;
      end
      ST_MAP: begin
        if (div_done) begin
          q_c <= quo0;
          q_r <= quo1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && slot_free) begin
      case (kind)
        K_POINT: begin
          out_item <= '{active: 1'b1, point_x: qx, point_y: qy,
                        avg_x: avg_x, avg_y: avg_y, avg_z: avg_z};
        end
        K_HOLD: begin
          out_item <= '{active: 1'b1, point_x: latch_x, point_y: latch_y,
                        avg_x: '0, avg_y: '0, avg_z: '0};
        end
        default: begin
          out_item <= '0;
        end
      endcase
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      kind       <= K_OFF;
      latched    <= 1'b0;
      latch_x    <= '0;
      latch_y    <= '0;
      miss_count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop) begin
            if (pop_job.is_clear) begin
              latched    <= 1'b0;
              miss_count <= '0;
            end else if (start_avg) begin
              kind  <= K_POINT;
              state <= ST_AVG;
            end else begin
              kind  <= (latched && miss_count < cfg.release_hold) ? K_HOLD : K_OFF;
              state <= ST_FIN;
            end
          end
        end
        ST_AVG: begin
          if (div_done) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_DIVST;
        end
        ST_DIVST: begin
          state <= ST_MAP;
        end
        ST_MAP: begin
          if (div_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            state <= ST_IDLE;
            case (kind)
              K_POINT: begin
                latched    <= 1'b1;
                latch_x    <= qx;
                latch_y    <= qy;
                miss_count <= '0;
              end
              K_HOLD: begin
                miss_count <= miss_count + HOLD_W'(1);
              end
              default: begin
                latched    <= 1'b0;
                miss_count <= '0;
              end
            endcase
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/touch_point_filter_mapper_unit.sv -----
// ----------------------------------------------------------------------------
// touch_point_filter_mapper_unit
// Averages raw touch frames and maps them onto a rotated 240x320 panel.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    cmd, pressed, sample_x/y/z
//  out_ch    out  valid/ready    active, point_x/y, avg_x/y/z
//  cfg       in   cfg_we only    cfg_index, cfg_data
//
//  a sample is accepted whenever the job queue has room
//  a frame with two or more valid samples passes in the back end
//  through an averaging divide and then a mapping divide
//  a held or released frame skips both divides, a clear gives no output
//  a stalled output holds the back end, the queue keeps the front going
//  rst is synchronous and clears sums, latch, queue and output
// ----------------------------------------------------------------------------
module touch_point_filter_mapper_unit (
  input  logic                             clk,
  input  logic                             rst,
  tpfm_in_if.sink                          in_ch,
  tpfm_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [tpfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpfm_pkg::CFG_W-1:0]       cfg_data
);
  import tpfm_pkg::*;

  cfg_t cfg;
  logic push, full, pop, empty;
  job_t push_job, pop_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cal_x_low       <= '0;
      cfg.cal_x_high      <= RAW_W'(4095);
      cfg.cal_y_low       <= '0;
      cfg.cal_y_high      <= RAW_W'(4095);
      cfg.pressure_min    <= '0;
      cfg.release_hold    <= HOLD_W'(2);
      cfg.orient_flags    <= '0;
      cfg.screen_rotation <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_X_LOW:    cfg.cal_x_low       <= cfg_data[RAW_W-1:0];
        REG_CAL_X_HIGH:   cfg.cal_x_high      <= cfg_data[RAW_W-1:0];
        REG_CAL_Y_LOW:    cfg.cal_y_low       <= cfg_data[RAW_W-1:0];
        REG_CAL_Y_HIGH:   cfg.cal_y_high      <= cfg_data[RAW_W-1:0];
        REG_PRESSURE_MIN: cfg.pressure_min    <= cfg_data[RAW_W-1:0];
        REG_RELEASE_HOLD: cfg.release_hold    <= cfg_data[HOLD_W-1:0];
        REG_ORIENT_FLAGS: cfg.orient_flags    <= cfg_data[ORIENT_W-1:0];
        REG_SCREEN_ROT:   cfg.screen_rotation <= cfg_data[ROT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tpfm_front u_front (
    .clk, .rst, .in_ch, .cfg, .push, .push_job, .full
  );

  tpfm_fifo u_fifo (
    .clk, .rst, .push, .push_job, .full, .pop, .pop_job, .empty
  );

  tpfm_back u_back (
    .clk, .rst, .cfg, .pop_job, .empty, .pop, .out_ch
  );

endmodule
